@@ rtl/tfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, constants and the CRC-16/MCRF4XX byte update for the
// telemetry frame checker.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int MAX_PAYLOAD = 255;
  localparam int HDR_BYTES   = 4;
  localparam int CHK_BYTES   = 2;
  localparam int MIN_FRAME   = HDR_BYTES + CHK_BYTES;
  localparam int MAX_FRAME   = HDR_BYTES + MAX_PAYLOAD + CHK_BYTES;

  // byte counter and a one-bit-wider width for frame size arithmetic
  localparam int POS_W = 9;
  localparam int CNT_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_SAT = '1;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_SIZE   = 3'd1,
    STATUS_BAD_MAGIC  = 3'd2,
    STATUS_BAD_LENGTH = 3'd3,
    STATUS_BAD_CHECK  = 3'd4
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } out_kind_t;

  typedef struct packed {
    out_kind_t     kind;
    logic [7:0]    payload_byte;
    logic [7:0]    payload_index;
    frame_status_t status;
    logic [7:0]    message_id;
    logic [7:0]    sequence_number;
    logic [7:0]    payload_length;
  } result_t;

  // reflected crc, one byte, eight unrolled bit steps
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/tfc_frame_state.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_frame_state
// Per-frame state: byte count, header fields, running crc and received
// checksum. Places one byte per step and forms that step's result.
// ----------------------------------------------------------------------------
module tfc_frame_state
  import tfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       byte_last,
  input  logic [7:0] frame_magic,
  output logic       res_valid,
  output result_t    res
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      crc_register, crc_register_next;
  logic [7:0]       header_magic, header_magic_next;
  logic [7:0]       declared_length, declared_length_next;
  logic [7:0]       header_message, header_message_next;
  logic [7:0]       header_sequence, header_sequence_next;
  logic [15:0]      received_check, received_check_next;

  logic             saturated;
  logic             in_header;
  logic             in_payload;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] check_pos;
  logic [CNT_W-1:0] frame_size;
  logic [CNT_W-1:0] expected_size;
  logic [7:0]       pay_index;

  always_comb begin
    saturated  = (byte_position == POS_SAT);
    pos_ext    = {1'b0, byte_position};
    check_pos  = CNT_W'(HDR_BYTES) + {{(CNT_W-8){1'b0}}, declared_length};
    in_header  = !saturated && (pos_ext < CNT_W'(HDR_BYTES));
    in_payload = !saturated && !in_header && (pos_ext < check_pos);
    pay_index  = 8'(pos_ext - CNT_W'(HDR_BYTES));

    byte_position_next   = saturated ? byte_position : byte_position + POS_W'(1);
    crc_register_next    = crc_register;
    header_magic_next    = header_magic;
    declared_length_next = declared_length;
    header_message_next  = header_message;
    header_sequence_next = header_sequence;
    received_check_next  = received_check;

    if (in_header) begin
      case (byte_position[1:0])
        2'd0:    header_magic_next    = rx_byte;
        2'd1:    declared_length_next = rx_byte;
        2'd2:    header_message_next  = rx_byte;
        default: header_sequence_next = rx_byte;
      endcase
    end
    if (in_header || in_payload) begin
      crc_register_next = crc16_feed(crc_register, rx_byte);
    end
    // checksum arrives low byte first
    if (!saturated && !in_header && pos_ext == check_pos) begin
      received_check_next[7:0] = rx_byte;
    end
    if (!saturated && !in_header && pos_ext == check_pos + CNT_W'(1)) begin
      received_check_next[15:8] = rx_byte;
    end

    frame_size    = pos_ext + CNT_W'(1);
    expected_size = CNT_W'(MIN_FRAME) + {{(CNT_W-8){1'b0}}, declared_length_next};

    res = '0;
    if (byte_last) begin
      res.kind            = KIND_STATUS;
      res.message_id      = header_message_next;
      res.sequence_number = header_sequence_next;
      res.payload_length  = declared_length_next;
      if (saturated || frame_size < CNT_W'(MIN_FRAME) || frame_size > CNT_W'(MAX_FRAME)) begin
        res.status = STATUS_BAD_SIZE;
      end else if (header_magic_next != frame_magic) begin
        res.status = STATUS_BAD_MAGIC;
      end else if ({{(CNT_W-8){1'b0}}, declared_length_next} > CNT_W'(MAX_PAYLOAD) ||
                   frame_size != expected_size) begin
        res.status = STATUS_BAD_LENGTH;
      end else if (received_check_next != crc_register_next) begin
        res.status = STATUS_BAD_CHECK;
      end else begin
        res.status = STATUS_OK;
      end
    end else begin
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.payload_index = pay_index;
    end
    res_valid = byte_last || in_payload;
  end

  // every frame end returns the state to its reset value
  always_ff @(posedge clk) begin
    if (rst || (step && byte_last)) begin
      byte_position   <= '0;
      crc_register    <= CRC_INIT;
      header_magic    <= '0;
      declared_length <= '0;
      header_message  <= '0;
      header_sequence <= '0;
      received_check  <= '0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      crc_register    <= crc_register_next;
      header_magic    <= header_magic_next;
      declared_length <= declared_length_next;
      header_message  <= header_message_next;
      header_sequence <= header_sequence_next;
      received_check  <= received_check_next;
    end
  end

endmodule

@@ rtl/telemetry_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_checker
// Checks received telemetry frames byte by byte: header, payload pass-through,
// CRC-16/MCRF4XX and an end-of-frame status.
// ----------------------------------------------------------------------------
// Accepts one byte per clock and keeps that rate as long as out_ready is high.
// A byte is captured in an input register, goes through the frame state logic
// (header capture, one unrolled 8-bit crc update, size and length compares)
// and lands in the output register. Payload bytes come out as they arrive, even
// for frames that later fail; the beat with byte_last gives the status and
// clears the frame state. frame_magic is written through cfg_write/cfg_data
// and should only change while no frame is in flight.
module telemetry_frame_checker
  import tfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       byte_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [2:0] frame_status,
  output logic [7:0] message_id,
  output logic [7:0] sequence_number,
  output logic [7:0] payload_length
);

  logic [7:0] frame_magic;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= '0;
    end else if (cfg_write) begin
      frame_magic <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
      in_last <= byte_last;
    end
  end

  tfc_frame_state u_state (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .rx_byte     (in_byte),
    .byte_last   (in_last),
    .frame_magic (frame_magic),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign out_kind        = out_res.kind;
  assign payload_byte    = out_res.payload_byte;
  assign payload_index   = out_res.payload_index;
  assign frame_status    = out_res.status;
  assign message_id      = out_res.message_id;
  assign sequence_number = out_res.sequence_number;
  assign payload_length  = out_res.payload_length;

endmodule

@@ rtl/tfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level assertions for the telemetry frame checker, bound to the top.
// ----------------------------------------------------------------------------
module tfc_checker
  import tfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] payload_byte,
  input logic [7:0] payload_index,
  input logic [2:0] frame_status,
  input logic [7:0] message_id,
  input logic [7:0] sequence_number,
  input logic [7:0] payload_length
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(payload_byte) && $stable(payload_index) && $stable(frame_status))
    else $error("stalled result beat changed");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_PAYLOAD |-> frame_status == STATUS_OK &&
      message_id == 8'd0 && sequence_number == 8'd0 && payload_length == 8'd0)
    else $error("payload beat carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS |-> payload_byte == 8'd0 && payload_index == 8'd0)
    else $error("status beat carries payload fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_status <= STATUS_BAD_CHECK)
    else $error("status code out of range");

endmodule

bind telemetry_frame_checker tfc_checker u_tfc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .payload_byte    (payload_byte),
  .payload_index   (payload_index),
  .frame_status    (frame_status),
  .message_id      (message_id),
  .sequence_number (sequence_number),
  .payload_length  (payload_length)
);
